[rtl/rwpc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, field widths and classification thresholds for the window pixel counter.
package rwpc_pkg;

    // Field widths
    localparam int PIX_W    = 16;
    localparam int COORD_W  = 10;
    localparam int EDGE_W   = 11;
    localparam int STRIDE_W = 12;
    localparam int COUNT_W  = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // Frame size limits; compares run at CMP_W bits so limits up to 8191 fit
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int CMP_W      = 13;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // RGB565 thresholds
    localparam logic [4:0] WHITE_R_MIN = 5'd24;
    localparam logic [5:0] WHITE_G_MIN = 6'd48;
    localparam logic [4:0] WHITE_B_MIN = 5'd24;
    localparam logic [4:0] BLUE_R_MAX  = 5'd10;
    localparam logic [5:0] BLUE_G_MIN  = 6'd24;
    localparam logic [4:0] BLUE_B_MIN  = 5'd18;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_START      = 3'd0,
        REG_X_END        = 3'd1,
        REG_Y_START      = 3'd2,
        REG_Y_END        = 3'd3,
        REG_STRIDE_BYTES = 3'd4,
        REG_MIN_COUNT    = 3'd5,
        REG_MATCH_MODE   = 3'd6
    } cfg_idx_t;

    // Current configuration
    typedef struct packed {
        logic [COORD_W-1:0]  x_start;
        logic [EDGE_W-1:0]   x_end;
        logic [COORD_W-1:0]  y_start;
        logic [EDGE_W-1:0]   y_end;
        logic [STRIDE_W-1:0] stride_bytes;
        logic [COUNT_W-1:0]  min_count;
        logic                match_mode;
    } cfg_t;

    // Per-pixel evaluation handed to the counter
    typedef struct packed {
        logic hit;
        logic win_valid;
    } pix_eval_t;

endpackage

[rtl/rwpc_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input, result output and register writes.
interface rwpc_pix_if import rwpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_value;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last_pixel;

    modport source (output valid, pixel_value, col, row, last_pixel, input ready);
    modport sink   (input valid, pixel_value, col, row, last_pixel, output ready);
endinterface

interface rwpc_res_if import rwpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;
    logic               passes;
    logic               window_invalid;

    modport source (output valid, match_count, passes, window_invalid, input ready);
    modport sink   (input valid, match_count, passes, window_invalid, output ready);
endinterface

interface rwpc_cfg_if import rwpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rwpc_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file written through the register write channel.
module rwpc_cfg_regs
    import rwpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rwpc_cfg_if.sink     cfg,
    output cfg_t         cfg_q
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    // Decode the write index; drop writes to unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_X_START:      cfg_next.x_start      = cfg.data[COORD_W-1:0];
                REG_X_END:        cfg_next.x_end        = cfg.data[EDGE_W-1:0];
                REG_Y_START:      cfg_next.y_start      = cfg.data[COORD_W-1:0];
                REG_Y_END:        cfg_next.y_end        = cfg.data[EDGE_W-1:0];
                REG_STRIDE_BYTES: cfg_next.stride_bytes = cfg.data[STRIDE_W-1:0];
                REG_MIN_COUNT:    cfg_next.min_count    = cfg.data[COUNT_W-1:0];
                REG_MATCH_MODE:   cfg_next.match_mode   = cfg.data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/rwpc_match.sv]
`timescale 1ns / 1ps
// Pixel color classification and window/stride test for one registered pixel.
module rwpc_match
    import rwpc_pkg::*;
(
    input  logic [PIX_W-1:0]   pixel_value,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  cfg_t               cfg_q,
    output pix_eval_t          eval
);

    logic [4:0]          red;
    logic [5:0]          green;
    logic [4:0]          blue;
    logic                is_white;
    logic                is_blue;
    logic                color_hit;
    logic                win_valid;
    logic                in_x;
    logic                in_y;
    logic                in_stride;
    logic                in_frame;
    logic [STRIDE_W-1:0] last_byte;

    // Split the 5-6-5 fields and classify
    assign red   = pixel_value[15:11];
    assign green = pixel_value[10:5];
    assign blue  = pixel_value[4:0];

    assign is_white  = (red >= WHITE_R_MIN) && (green >= WHITE_G_MIN) && (blue >= WHITE_B_MIN);
    assign is_blue   = (red <= BLUE_R_MAX) && (green >= BLUE_G_MIN) && (blue >= BLUE_B_MIN);
    assign color_hit = is_white || (cfg_q.match_mode && is_blue);

    // Window must be non-empty and stride nonzero
    assign win_valid = (cfg_q.x_end > {1'b0, cfg_q.x_start})
                    && (cfg_q.y_end > {1'b0, cfg_q.y_start})
                    && (cfg_q.stride_bytes != '0);

    // Half-open window bounds
    assign in_x = (col >= cfg_q.x_start) && ({1'b0, col} < cfg_q.x_end);
    assign in_y = (row >= cfg_q.y_start) && ({1'b0, row} < cfg_q.y_end);

    // Last byte of the pixel must lie inside the row stride
    assign last_byte = {1'b0, col, 1'b1};
    assign in_stride = last_byte < cfg_q.stride_bytes;

    // Pixels past the frame limits never count
    assign in_frame = (CMP_W'(col) < CMP_W'(MAX_WIDTH)) && (CMP_W'(row) < CMP_W'(MAX_HEIGHT));

    assign eval.hit       = win_valid && in_x && in_y && in_stride && in_frame && color_hit;
    assign eval.win_valid = win_valid;

endmodule

[rtl/rgb565_window_pixel_counter.sv]
`timescale 1ns / 1ps
// Top level: input register, pixel evaluation, saturating counter and result register.
//
//  channel | dir | fields                                  | transfer
//  pix     | in  | pixel_value, col, row, last_pixel       | valid & ready
//  res     | out | match_count, passes, window_invalid     | valid & ready
//  cfg     | in  | index, data                             | valid & ready (ready tied high)
//
// One pixel per cycle unless a frame end stalls: a pixel is held in the input register, is
// evaluated and counted on the way out; the result of a last pixel is registered in the cycle after.
// Reset clears configuration, count and valid flags. The input register drains into
// the counter unless it holds a last pixel and the result register is still occupied,
// so a stalled result only holds the input back once a second frame end arrives.
module rgb565_window_pixel_counter
    import rwpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rwpc_pix_if.sink  pix,
    rwpc_res_if.source res,
    rwpc_cfg_if.sink  cfg
);

    cfg_t               cfg_q;
    pix_eval_t          eval;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [COORD_W-1:0] s1_col_reg;
    logic [COORD_W-1:0] s1_row_reg;
    logic               s1_last_reg;
    logic               s1_fire;
    logic               pix_accept;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_upd;

    logic               res_valid_reg;
    logic               res_valid_next;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_passes_reg;
    logic               res_invalid_reg;
    logic [COUNT_W-1:0] frame_count;

    rwpc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    rwpc_match u_match (
        .pixel_value (s1_pix_reg),
        .col         (s1_col_reg),
        .row         (s1_row_reg),
        .cfg_q       (cfg_q),
        .eval        (eval)
    );

    // Drain the input register unless a frame end finds the result slot full
    assign s1_fire    = s1_valid_reg && (!s1_last_reg || !res_valid_reg || res.ready);
    assign pix.ready  = !s1_valid_reg || s1_fire;
    assign pix_accept = pix.valid && pix.ready;

    assign s1_valid_next = pix_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    // Advance the saturating count
    assign count_upd   = (eval.hit && (count_reg != COUNT_MAX)) ? count_reg + 1'b1 : count_reg;
    assign frame_count = eval.win_valid ? count_upd : '0;

    always_comb
    begin
        count_next = count_reg;
        if (s1_fire)
        begin
            count_next = s1_last_reg ? '0 : count_upd;
        end
    end

    // Present a result after each frame end; hold it until taken
    always_comb
    begin
        res_valid_next = res_valid_reg && !res.ready;
        if (s1_fire && s1_last_reg)
        begin
            res_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Capture the pixel transaction
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_pix_reg  <= pix.pixel_value;
            s1_col_reg  <= pix.col;
            s1_row_reg  <= pix.row;
            s1_last_reg <= pix.last_pixel;
        end
    end

    // Load the result payload at a frame end
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            res_count_reg   <= frame_count;
            res_passes_reg  <= eval.win_valid && (frame_count >= cfg_q.min_count);
            res_invalid_reg <= !eval.win_valid;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.match_count    = res_count_reg;
    assign res.passes         = res_passes_reg;
    assign res.window_invalid = res_invalid_reg;

`ifndef SYNTHESIS
    // An invalid window reports an empty, failing count
    a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_invalid_reg) |-> (res_count_reg == '0 && !res_passes_reg))
        else $error("invalid window reported a nonzero count or a pass");

    // The count restarts after every frame end
    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (count_reg == '0))
        else $error("count not cleared after frame end");

    // Within a frame the count never falls
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_last_reg) |=> (count_reg >= $past(count_reg)))
        else $error("count decreased within a frame");
`endif

endmodule
